// File: hdl/assert_macros.svh
// ============================================================================
// Assertion macros
// Shared concurrent assertion forms for the register server RTL.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked every clock, off while reset is high.
`define MBRS_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// Condition that must never be seen, off while reset is high.
`define MBRS_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("forbidden condition seen");

`endif

// File: hdl/mbrs_pkg.sv
// ============================================================================
// mbrs_pkg
// Types, codes and the CRC-16 step of the register server.
// ============================================================================
`default_nettype none

package mbrs_pkg;

   typedef struct packed {
      logic [2:0]  opcode;
      logic [7:0]  rx_byte;
      logic [5:0]  reg_index;
      logic [15:0] reg_value;
   } req_type;

   typedef struct packed {
      logic        out_kind;
      logic [7:0]  tx_byte;
      logic        last_byte;
      logic [15:0] read_value;
      logic        holding_written;
   } rsp_type;

   localparam logic [2:0] OP_RX_BYTE   = 3'd0;
   localparam logic [2:0] OP_FRAME_END = 3'd1;
   localparam logic [2:0] OP_WR_INPUT  = 3'd2;
   localparam logic [2:0] OP_WR_HOLD   = 3'd3;
   localparam logic [2:0] OP_RD_HOLD   = 3'd4;

   localparam logic [7:0] FC_READ_HOLD  = 8'd3;
   localparam logic [7:0] FC_READ_INPUT = 8'd4;
   localparam logic [7:0] FC_WRITE_ONE  = 8'd6;

   localparam logic [7:0] EXC_ILLEGAL_FUNC = 8'd1;
   localparam logic [7:0] EXC_ILLEGAL_ADDR = 8'd2;
   localparam logic [7:0] EXC_FLAG         = 8'b1000_0000;

   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'hA001;
   localparam logic [3:0]  FRAME_LEN = 4'd8;

   localparam logic       KIND_TX   = 1'b0;
   localparam logic       KIND_READ = 1'b1;

   // one byte through the reflected CRC-16, bit by bit
   function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) c = (c >> 1) ^ CRC_POLY;
         else      c = c >> 1;
      end
      return c;
   endfunction

endpackage

`default_nettype wire

// File: hdl/modbus_rtu_register_server_top.sv
// ============================================================================
// modbus_rtu_register_server_top
// Modbus RTU slave: receives frame bytes, checks CRC-16 and address, serves
// function 3/4 reads and function 6 writes from two register memories.
// ============================================================================
//
//  channel | ports                    | handshake
//  --------+--------------------------+------------------------------
//  request | req_valid/ready/data     | accepted when valid && ready
//  reply   | rsp_valid/ready/data     | accepted when valid && ready
//  config  | csr_we, csr_wdata        | written when csr_we is high
//
// Received bytes, host writes: one per clock while idle (CRC step is one byte per clock).
// Host read: the registered memory read port gives the value, then ST_HREAD loads the reply.
// Frame end: the reply bytes are sent one at a time, with an ST_FETCH memory
// fetch before each register read.
// After reset a clearing pass writes zero into both memories, one entry a
// cycle, over max(INPUT_REG_COUNT, HOLDING_REG_COUNT) entries; req_ready is low.
// A stalled rsp_ready holds the reply byte and the sequencer waits on it.
`default_nettype none

module modbus_rtu_register_server_top #(
   parameter int INPUT_REG_COUNT   = 64,
   parameter int HOLDING_REG_COUNT = 64,
   parameter int MAX_READ_COUNT    = 16
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire mbrs_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output mbrs_pkg::rsp_type      rsp_data,
   input  wire logic              csr_we,
   input  wire logic [7:0]        csr_wdata
);
   import mbrs_pkg::*;

   localparam int MAX_COUNT = (INPUT_REG_COUNT > HOLDING_REG_COUNT) ?
                              INPUT_REG_COUNT : HOLDING_REG_COUNT;
   localparam int IAW = (INPUT_REG_COUNT > 1) ? $clog2(INPUT_REG_COUNT) : 1;
   localparam int HAW = (HOLDING_REG_COUNT > 1) ? $clog2(HOLDING_REG_COUNT) : 1;
   localparam int PW  = $clog2(MAX_COUNT + 1);   // pointer / clear counter
   localparam int CW  = $clog2(MAX_READ_COUNT + 1);

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_HREAD, ST_HDR, ST_FETCH, ST_DHI, ST_DLO, ST_CRCL, ST_CRCH
   } state_type;

   typedef enum logic [1:0] {MODE_READ, MODE_WRITE, MODE_EXC} mode_type;

   state_type   state_ff;
   mode_type    mode_ff;
   logic [7:0]  dev_addr_ff;
   logic [7:0]  frame_ff [8];
   logic [3:0]  byte_cnt_ff;
   logic [15:0] crc_ff;
   logic [15:0] tx_crc_ff;
   logic [7:0]  exc_code_ff;
   logic [2:0]  hdr_pos_ff;
   logic [CW-1:0] word_cnt_ff;
   logic [PW-1:0] ptr_ff;
   logic [PW-1:0] clr_ptr_ff;
   logic        tbl_input_ff;
   logic        hrd_oor_ff;
   logic        rsp_valid_ff;
   rsp_type     rsp_ff;

   // register memories, registered read
   logic [15:0] imem_ff [INPUT_REG_COUNT];
   logic [15:0] hmem_ff [HOLDING_REG_COUNT];
   logic [15:0] ird_ff, hrd_ff;

   logic          accept, emit_ok, emit_now, frame_ok;
   logic [15:0]   first16, word16, idx16;
   logic [16:0]   sum17;
   logic [PW-1:0] rd_addr;
   logic          iwe, hwe;
   logic [IAW-1:0] iwaddr;
   logic [HAW-1:0] hwaddr;
   logic [15:0]   iwdata, hwdata, rdata;
   logic [7:0]    hdr_byte;
   logic [15:0]   tx_crc_in;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign emit_ok   = !rsp_valid_ff || rsp_ready;
   // a new response byte is loaded this cycle
   assign emit_now  = emit_ok && (state_ff == ST_HREAD || state_ff == ST_HDR ||
                                  state_ff == ST_DHI || state_ff == ST_DLO ||
                                  state_ff == ST_CRCL || state_ff == ST_CRCH);

   assign first16  = {frame_ff[2], frame_ff[3]};
   assign word16   = {frame_ff[4], frame_ff[5]};
   assign sum17    = {1'b0, first16} + {1'b0, word16};
   assign idx16    = {10'd0, req_data.reg_index};
   assign frame_ok = (byte_cnt_ff == FRAME_LEN) && (crc_ff == 16'h0000) &&
                     (frame_ff[0] == dev_addr_ff);
   assign rdata    = tbl_input_ff ? ird_ff : hrd_ff;
   assign rd_addr  = (state_ff == ST_IDLE) ? idx16[PW-1:0] : ptr_ff;

   // memory write port: clearing pass, host writes, function 6
   always_comb begin
      iwe = 1'b0; hwe = 1'b0;
      iwaddr = idx16[IAW-1:0]; hwaddr = idx16[HAW-1:0];
      iwdata = req_data.reg_value; hwdata = req_data.reg_value;
      if (state_ff == ST_CLEAR) begin
         iwe = ({{(32-PW){1'b0}}, clr_ptr_ff} < 32'(INPUT_REG_COUNT));
         hwe = ({{(32-PW){1'b0}}, clr_ptr_ff} < 32'(HOLDING_REG_COUNT));
         iwaddr = clr_ptr_ff[IAW-1:0]; hwaddr = clr_ptr_ff[HAW-1:0];
         iwdata = 16'h0000; hwdata = 16'h0000;
      end else if (accept) begin
         case (req_data.opcode)
            OP_WR_INPUT: iwe = (idx16 < 16'(INPUT_REG_COUNT));
            OP_WR_HOLD:  hwe = (idx16 < 16'(HOLDING_REG_COUNT));
            OP_FRAME_END: begin
               if (frame_ok && frame_ff[1] == FC_WRITE_ONE &&
                   first16 < 16'(HOLDING_REG_COUNT)) begin
                  hwe = 1'b1;
                  hwaddr = first16[HAW-1:0];
                  hwdata = word16;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (iwe) imem_ff[iwaddr] <= iwdata;
      if (hwe) hmem_ff[hwaddr] <= hwdata;
      ird_ff <= imem_ff[rd_addr[IAW-1:0]];
      hrd_ff <= hmem_ff[rd_addr[HAW-1:0]];
   end

   // header byte of the reply at hdr_pos, and the reply CRC step for the byte sent
   always_comb begin
      case (hdr_pos_ff)
         3'd0: hdr_byte = frame_ff[0];
         3'd1: hdr_byte = (mode_ff == MODE_EXC) ? (frame_ff[1] | EXC_FLAG) : frame_ff[1];
         3'd2: begin
            case (mode_ff)
               MODE_EXC:  hdr_byte = exc_code_ff;
               MODE_READ: hdr_byte = {frame_ff[5][6:0], 1'b0};
               default:   hdr_byte = frame_ff[2];
            endcase
         end
         3'd3: hdr_byte = frame_ff[3];
         3'd4: hdr_byte = frame_ff[4];
         default: hdr_byte = frame_ff[5];
      endcase
      case (state_ff)
         ST_DHI:  tx_crc_in = crc16_byte(tx_crc_ff, rdata[15:8]);
         ST_DLO:  tx_crc_in = crc16_byte(tx_crc_ff, rdata[7:0]);
         default: tx_crc_in = crc16_byte(tx_crc_ff, hdr_byte);
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ptr_ff   <= '0;
         dev_addr_ff  <= 8'd1;
         byte_cnt_ff  <= 4'd0;
         crc_ff       <= CRC_INIT;
         rsp_valid_ff <= 1'b0;
         mode_ff      <= MODE_EXC;
         hdr_pos_ff   <= 3'd0;
      end else begin
         if (csr_we) dev_addr_ff <= csr_wdata;
         if (rsp_valid_ff && rsp_ready && !emit_now) rsp_valid_ff <= 1'b0;
         case (state_ff)
            ST_CLEAR: begin
               clr_ptr_ff <= clr_ptr_ff + PW'(1);
               if (clr_ptr_ff == PW'(MAX_COUNT - 1)) state_ff <= ST_IDLE;
            end
            ST_IDLE: begin
               if (accept) begin
                  case (req_data.opcode)
                     OP_RX_BYTE: begin
                        crc_ff <= crc16_byte(crc_ff, req_data.rx_byte);
                        if (byte_cnt_ff < FRAME_LEN)
                           frame_ff[byte_cnt_ff[2:0]] <= req_data.rx_byte;
                        if (byte_cnt_ff <= FRAME_LEN) byte_cnt_ff <= byte_cnt_ff + 4'd1;
                     end
                     OP_FRAME_END: begin
                        byte_cnt_ff <= 4'd0;
                        crc_ff      <= CRC_INIT;
                        tx_crc_ff   <= CRC_INIT;
                        hdr_pos_ff  <= 3'd0;
                        if (frame_ok) begin
                           state_ff <= ST_HDR;
                           tbl_input_ff <= (frame_ff[1] == FC_READ_INPUT);
                           if (frame_ff[1] == FC_READ_HOLD ||
                               frame_ff[1] == FC_READ_INPUT) begin
                              if (sum17 > 17'((frame_ff[1] == FC_READ_INPUT) ?
                                              INPUT_REG_COUNT : HOLDING_REG_COUNT) ||
                                  word16 > 16'(MAX_READ_COUNT)) begin
                                 mode_ff <= MODE_EXC;
                                 exc_code_ff <= EXC_ILLEGAL_ADDR;
                              end else begin
                                 mode_ff <= MODE_READ;
                                 ptr_ff <= first16[PW-1:0];
                                 word_cnt_ff <= word16[CW-1:0];
                              end
                           end else if (frame_ff[1] == FC_WRITE_ONE) begin
                              if (first16 >= 16'(HOLDING_REG_COUNT)) begin
                                 mode_ff <= MODE_EXC;
                                 exc_code_ff <= EXC_ILLEGAL_ADDR;
                              end else begin
                                 mode_ff <= MODE_WRITE;
                              end
                           end else begin
                              mode_ff <= MODE_EXC;
                              exc_code_ff <= EXC_ILLEGAL_FUNC;
                           end
                        end
                     end
                     OP_RD_HOLD: begin
                        // keep the index so a stalled reply still reads the same entry
                        ptr_ff     <= idx16[PW-1:0];
                        hrd_oor_ff <= (idx16 >= 16'(HOLDING_REG_COUNT));
                        state_ff   <= ST_HREAD;
                     end
                     default: ;
                  endcase
               end
            end
            ST_HREAD: begin
               if (emit_ok) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_ff <= '{out_kind: KIND_READ, tx_byte: 8'd0, last_byte: 1'b1,
                              read_value: hrd_oor_ff ? 16'd0 : hrd_ff,
                              holding_written: 1'b0};
                  state_ff <= ST_IDLE;
               end
            end
            ST_HDR: begin
               if (emit_ok) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_ff <= '{out_kind: KIND_TX, tx_byte: hdr_byte, last_byte: 1'b0,
                              read_value: 16'd0,
                              holding_written: (mode_ff == MODE_WRITE)};
                  tx_crc_ff  <= tx_crc_in;
                  hdr_pos_ff <= hdr_pos_ff + 3'd1;
                  if (hdr_pos_ff == ((mode_ff == MODE_WRITE) ? 3'd5 : 3'd2)) begin
                     if (mode_ff == MODE_READ && word_cnt_ff != '0) state_ff <= ST_FETCH;
                     else state_ff <= ST_CRCL;
                  end
               end
            end
            ST_FETCH: state_ff <= ST_DHI;
            ST_DHI: begin
               if (emit_ok) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_ff <= '{out_kind: KIND_TX, tx_byte: rdata[15:8], last_byte: 1'b0,
                              read_value: 16'd0, holding_written: 1'b0};
                  tx_crc_ff <= tx_crc_in;
                  state_ff  <= ST_DLO;
               end
            end
            ST_DLO: begin
               if (emit_ok) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_ff <= '{out_kind: KIND_TX, tx_byte: rdata[7:0], last_byte: 1'b0,
                              read_value: 16'd0, holding_written: 1'b0};
                  tx_crc_ff   <= tx_crc_in;
                  ptr_ff      <= ptr_ff + PW'(1);
                  word_cnt_ff <= word_cnt_ff - CW'(1);
                  state_ff    <= (word_cnt_ff == CW'(1)) ? ST_CRCL : ST_FETCH;
               end
            end
            ST_CRCL: begin
               if (emit_ok) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_ff <= '{out_kind: KIND_TX, tx_byte: tx_crc_ff[7:0], last_byte: 1'b0,
                              read_value: 16'd0,
                              holding_written: (mode_ff == MODE_WRITE)};
                  state_ff <= ST_CRCH;
               end
            end
            ST_CRCH: begin
               if (emit_ok) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_ff <= '{out_kind: KIND_TX, tx_byte: tx_crc_ff[15:8], last_byte: 1'b1,
                              read_value: 16'd0,
                              holding_written: (mode_ff == MODE_WRITE)};
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

`include "assert_macros.svh"

   `MBRS_NEVER(a_cnt_sat, clock, reset, byte_cnt_ff > 4'd9)
   `MBRS_ASSERT(a_hdr_pos, clock, reset, (state_ff == ST_HDR) |-> (hdr_pos_ff <= 3'd5))
   `MBRS_ASSERT(a_clear_blocks, clock, reset, (state_ff == ST_CLEAR) |-> !req_ready)
   `MBRS_ASSERT(a_read_last, clock, reset,
      (rsp_valid && rsp_data.out_kind == KIND_READ) |-> rsp_data.last_byte)

endmodule

`default_nettype wire
